[src/rational_arith_unit_macros.svh]
// assertion helpers for the rational arithmetic unit
`ifndef RATIONAL_ARITH_UNIT_MACROS_SVH
`define RATIONAL_ARITH_UNIT_MACROS_SVH

// implication checked on every clock, masked while in reset
`define RAU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked while in reset
`define RAU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/rau_pkg.sv]
package rau_pkg;

    localparam int WORD_BITS = 32;
    localparam int MAG_BITS  = 2 * WORD_BITS;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_MOD = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    typedef struct packed {
        logic [2:0]  operation;
        logic signed [31:0] a_num;
        logic signed [31:0] a_den;
        logic signed [31:0] b_num;
        logic signed [31:0] b_den;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] res_num;
        logic signed [31:0] res_den;
        logic [1:0]  status;
    } t_out_item;

endpackage

[src/rational_arith_unit.sv]
// rational arithmetic unit: combines two signed fractions a_num/a_den and
// b_num/b_den with add, subtract, multiply, divide or modulo and returns
// the fraction reduced by the gcd of numerator and denominator.
// input channel: i_item is taken at a clock edge where i_start is high and
// o_busy is low; o_busy then stays high until the result is shown.
// output channel: o_item is valid for exactly one cycle with o_done high;
// the receiver cannot stall it. o_busy is already low in that cycle, so
// the next item can be taken at the edge that ends it.
// sequence from the accepting edge to o_done: four 32x32 products (one a
// cycle), a combine step, then a gcd by Euclid where each remainder
// step is a 64-bit shift-subtract division plus one control step, then
// two divisions by the gcd and a range check; modulo adds one division
// first. divide-by-zero errors, unused codes and the trivial divide
// results go from the combine step straight to the output.
// all division work runs on one shared shift-subtract unit.
// reset: synchronous, active low, returns the sequencer to idle.
module rational_arith_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  rau_pkg::t_in_item    i_item,
    output logic                 o_busy,
    output logic                 o_done,
    output rau_pkg::t_out_item   o_item
);
    import rau_pkg::*;

    localparam int CNT_BITS = $clog2(MAG_BITS + 1);
    localparam logic [MAG_BITS-1:0] FIT_LIM = MAG_BITS'(1) << (WORD_BITS - 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL   = 4'd1;
    localparam logic [3:0] S_COMB  = 4'd2;
    localparam logic [3:0] S_MODD  = 4'd3;
    localparam logic [3:0] S_GCD   = 4'd4;
    localparam logic [3:0] S_GCDD  = 4'd5;
    localparam logic [3:0] S_DIVN  = 4'd6;
    localparam logic [3:0] S_DIVD  = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;
    localparam logic [3:0] S_GLD   = 4'd10;

    logic [3:0]          r_state;
    logic [2:0]          r_op;
    logic [WORD_BITS-1:0] r_mag [4];
    logic [3:0]          r_neg;
    logic [1:0]          r_mi;
    logic [MAG_BITS-1:0] r_p [4];
    logic [3:0]          r_pn;
    logic [MAG_BITS-1:0] r_nm, r_dm, r_x, r_y;
    logic                r_nn, r_dn;
    // shared shift-subtract divider
    logic [MAG_BITS-1:0] r_q, r_rem, r_dvs;
    logic [CNT_BITS-1:0] r_cnt;
    logic                r_done;
    t_out_item           r_out;
    logic                r_busy;

    logic [WORD_BITS-1:0] w_f [4];
    logic [WORD_BITS-1:0] w_ma, w_mb;
    logic                 w_na, w_nb;
    logic [MAG_BITS-1:0]  w_pr;
    logic                 w_bs;
    logic [MAG_BITS-1:0]  w_cn_m, w_cd_m;
    logic                 w_cn_s, w_cd_s;
    logic [MAG_BITS:0]    w_trial;
    logic [MAG_BITS-1:0]  w_rsh, w_rnext, w_qnext;
    logic                 w_fit_n, w_fit_d;
    logic signed [WORD_BITS-1:0] w_rn, w_rd;

    // the four operand fields; sign and magnitude are taken when accepted
    always_comb begin
        w_f[0] = i_item.a_num[WORD_BITS-1:0];
        w_f[1] = i_item.a_den[WORD_BITS-1:0];
        w_f[2] = i_item.b_num[WORD_BITS-1:0];
        w_f[3] = i_item.b_den[WORD_BITS-1:0];
    end

    // product operands: an*bd, ad*bn, an*bn, ad*bd
    always_comb begin
        case (r_mi)
            2'd0: begin
                w_ma = r_mag[0]; w_mb = r_mag[3]; w_na = r_neg[0]; w_nb = r_neg[3];
            end
            2'd1: begin
                w_ma = r_mag[1]; w_mb = r_mag[2]; w_na = r_neg[1]; w_nb = r_neg[2];
            end
            2'd2: begin
                w_ma = r_mag[0]; w_mb = r_mag[2]; w_na = r_neg[0]; w_nb = r_neg[2];
            end
            default: begin
                w_ma = r_mag[1]; w_mb = r_mag[3]; w_na = r_neg[1]; w_nb = r_neg[3];
            end
        endcase
        w_pr = MAG_BITS'(w_ma) * MAG_BITS'(w_mb);
    end

    // numerator and denominator before reduction
    always_comb begin
        w_bs   = r_pn[1] ^ (r_op == OP_SUB);
        w_cd_m = r_p[3];
        w_cd_s = r_pn[3];
        case (r_op)
            OP_ADD, OP_SUB: begin
                if (r_pn[0] == w_bs) begin
                    w_cn_m = r_p[0] + r_p[1]; w_cn_s = r_pn[0];
                end else if (r_p[0] >= r_p[1]) begin
                    w_cn_m = r_p[0] - r_p[1]; w_cn_s = r_pn[0];
                end else begin
                    w_cn_m = r_p[1] - r_p[0]; w_cn_s = w_bs;
                end
            end
            OP_MUL: begin
                w_cn_m = r_p[2]; w_cn_s = r_pn[2];
            end
            default: begin
                // divide: an*bd over ad*bn
                w_cn_m = r_p[0]; w_cn_s = r_pn[0];
                w_cd_m = r_p[1]; w_cd_s = r_pn[1];
            end
        endcase
    end

    // one divider step: shift the next dividend bit into the remainder
    assign w_rsh   = {r_rem[MAG_BITS-2:0], r_q[MAG_BITS-1]};
    assign w_trial = {1'b0, w_rsh} - {1'b0, r_dvs};
    assign w_rnext = w_trial[MAG_BITS] ? w_rsh : w_trial[MAG_BITS-1:0];
    assign w_qnext = {r_q[MAG_BITS-2:0], ~w_trial[MAG_BITS]};

    // range check and signed result words
    assign w_fit_n = r_nn ? (r_nm <= FIT_LIM) : (r_nm < FIT_LIM);
    assign w_fit_d = r_dn ? (r_dm <= FIT_LIM) : (r_dm < FIT_LIM);
    assign w_rn = r_nn ? (~r_nm[WORD_BITS-1:0] + WORD_BITS'(1)) : r_nm[WORD_BITS-1:0];
    assign w_rd = r_dn ? (~r_dm[WORD_BITS-1:0] + WORD_BITS'(1)) : r_dm[WORD_BITS-1:0];

    // sequencer and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_state == S_OUT);
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        for (int k = 0; k < 4; k++) begin
                            r_neg[k] <= w_f[k][WORD_BITS-1];
                            r_mag[k] <= w_f[k][WORD_BITS-1] ? (~w_f[k] + WORD_BITS'(1))
                                                            : w_f[k];
                        end
                        r_op    <= i_item.operation;
                        r_mi    <= 2'd0;
                        r_busy  <= 1'b1;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    // one product per cycle
                    r_p[r_mi]  <= w_pr;
                    r_pn[r_mi] <= (w_pr != '0) && (w_na != w_nb);
                    r_mi <= r_mi + 2'd1;
                    if (r_mi == 2'd3) r_state <= S_COMB;
                end
                S_COMB: begin
                    if (r_op > OP_MOD) begin
                        r_out   <= '{res_num: '0, res_den: '0, status: ST_OK};
                        r_state <= S_OUT;
                    end else if (r_mag[1] == '0 || r_mag[3] == '0 ||
                                 (r_op inside {OP_DIV, OP_MOD} && r_mag[2] == '0)) begin
                        r_out   <= '{res_num: '0, res_den: '0, status: ST_DIV0};
                        r_state <= S_OUT;
                    end else if (r_op == OP_DIV && r_p[0] == r_p[1] &&
                                 r_pn[0] == r_pn[1]) begin
                        r_out   <= '{res_num: 32'sd1, res_den: 32'sd1, status: ST_OK};
                        r_state <= S_OUT;
                    end else if (r_op == OP_DIV && r_mag[0] == '0) begin
                        r_out   <= '{res_num: '0, res_den: 32'sd1, status: ST_OK};
                        r_state <= S_OUT;
                    end else if (r_op == OP_MOD) begin
                        // modulo: remainder of an*bd by ad*bn
                        r_q <= r_p[0]; r_rem <= '0; r_dvs <= r_p[1]; r_cnt <= '0;
                        r_dm <= r_p[3]; r_dn <= r_pn[3];
                        r_state <= S_MODD;
                    end else begin
                        r_nm <= w_cn_m; r_nn <= w_cn_s;
                        r_dm <= w_cd_m; r_dn <= w_cd_s;
                        r_state <= S_GLD;
                    end
                end
                S_MODD, S_GCDD, S_DIVN, S_DIVD: begin
                    if (r_cnt != CNT_BITS'(MAG_BITS - 1)) begin
                        r_rem <= w_rnext;
                        r_q   <= w_qnext;
                        r_cnt <= r_cnt + CNT_BITS'(1);
                    end else begin
                        case (r_state)
                            S_MODD: begin
                                r_nm <= w_rnext;
                                r_nn <= r_pn[0] && (w_rnext != '0);
                                r_state <= S_GLD;
                            end
                            S_GCDD: begin
                                r_x <= r_y;
                                r_y <= w_rnext;
                                r_state <= S_GCD;
                            end
                            S_DIVN: begin
                                r_nm <= w_qnext;
                                r_q <= r_dm; r_rem <= '0; r_cnt <= '0;
                                r_state <= S_DIVD;
                            end
                            default: begin
                                r_dm <= w_qnext;
                                r_state <= S_FIN;
                            end
                        endcase
                    end
                end
                S_GLD: begin
                    // gcd operands
                    r_x <= r_nm;
                    r_y <= r_dm;
                    r_state <= S_GCD;
                end
                S_GCD: begin
                    // one Euclid step per pass until the remainder is zero
                    if (r_y != '0) begin
                        r_q <= r_x; r_rem <= '0; r_dvs <= r_y; r_cnt <= '0;
                        r_state <= S_GCDD;
                    end else if (r_x == '0) begin
                        r_state <= S_FIN;
                    end else begin
                        r_q <= r_nm; r_rem <= '0; r_dvs <= r_x; r_cnt <= '0;
                        r_nn <= r_nn && (r_nm != '0);
                        r_state <= S_DIVN;
                    end
                end
                S_FIN: begin
                    if (!w_fit_n || !w_fit_d) begin
                        r_out <= '{res_num: '0, res_den: '0, status: ST_OVF};
                    end else begin
                        r_out <= '{res_num: 32'(w_rn), res_den: 32'(w_rd),
                                   status: ST_OK};
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_busy  <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_item = r_out;

`include "rational_arith_unit_macros.svh"

    `RAU_ASSERT_IMP(a_done_from_out, i_clk, i_rst_n, o_done, !o_busy,
        "result strobe while still busy")
    `RAU_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy,
        "accepted item did not raise busy")
    `RAU_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, o_done && o_item.status != ST_OK,
        o_item.res_num == '0 && o_item.res_den == '0, "error result not zero")

endmodule
